@@ sv/srle_pkg.sv @@
// Shared types and codes for the sorted request list engine.
// Holds operation and status codes and the controller/datapath command and status bundles.
// No dependencies.
package srle_pkg;

  localparam int FUNC_BITS   = 4;
  localparam int STATUS_BITS = 2;

  // Operation codes carried in the func field.
  localparam logic [FUNC_BITS-1:0] FUNC_PUSH_FRONT = 4'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_PUSH_BACK  = 4'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_DEST_ASC   = 4'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_DEST_DESC  = 4'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_CALL_ASC   = 4'd4;
  localparam logic [FUNC_BITS-1:0] FUNC_CALL_DESC  = 4'd5;
  localparam logic [FUNC_BITS-1:0] FUNC_POP        = 4'd6;
  localparam logic [FUNC_BITS-1:0] FUNC_REMOVE     = 4'd7;
  localparam logic [FUNC_BITS-1:0] FUNC_QUERY      = 4'd8;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 2'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd3;

  // Read address selection for the entry memory.
  typedef enum logic [2:0] {
    RD_IDX,
    RD_IDX_PREV,
    RD_IDX_NEXT,
    RD_FRONT,
    RD_BACK
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                   load;
    logic                   idx_clr;
    logic                   idx_to_occ;
    logic                   idx_inc;
    logic                   idx_dec;
    logic                   pos_zero;
    logic                   pos_occ;
    logic                   pos_idx;
    logic                   mem_rd;
    rd_sel_t                rd_sel;
    logic                   wr_move;
    logic                   wr_new;
    logic                   occ_inc;
    logic                   occ_dec;
    logic                   set_status;
    logic [STATUS_BITS-1:0] status_code;
    logic                   cap_front;
    logic                   cap_back;
    logic                   clr_result;
  } srle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_insert;
    logic op_front;
    logic op_back;
    logic op_pop;
    logic op_remove;
    logic full;
    logic empty;
    logic idx_at_occ;
    logic idx_at_pos;
    logic close_end;
    logic key_stop;
    logic tag_hit;
  } srle_stat_t;

endpackage

@@ sv/srle_in_if.sv @@
// Request channel interface of the sorted request list engine.
// Carries valid, ready and one request item; uses srle_pkg for the func width.
interface srle_in_if #(
  parameter int TAG_BITS   = 8,
  parameter int FLOOR_BITS = 6
);
  logic                           valid;
  logic                           ready;
  logic [srle_pkg::FUNC_BITS-1:0] func;
  logic [TAG_BITS-1:0]            user_tag;
  logic [FLOOR_BITS-1:0]          call_floor;
  logic [FLOOR_BITS-1:0]          dest_floor;

  modport source (output valid, func, user_tag, call_floor, dest_floor, input ready);
  modport sink   (input valid, func, user_tag, call_floor, dest_floor, output ready);
endinterface

@@ sv/srle_out_if.sv @@
// Result channel interface of the sorted request list engine.
// Carries valid, ready and one result item; uses srle_pkg for the status width.
interface srle_out_if #(
  parameter int TAG_BITS   = 8,
  parameter int FLOOR_BITS = 6,
  parameter int COUNT_BITS = 5
);
  logic                             valid;
  logic                             ready;
  logic [srle_pkg::STATUS_BITS-1:0] status;
  logic [COUNT_BITS-1:0]            entry_count;
  logic                             front_valid;
  logic [TAG_BITS-1:0]              front_tag;
  logic [FLOOR_BITS-1:0]            front_call;
  logic [FLOOR_BITS-1:0]            front_dest;
  logic                             back_valid;
  logic [TAG_BITS-1:0]              back_tag;
  logic [FLOOR_BITS-1:0]            back_call;
  logic [FLOOR_BITS-1:0]            back_dest;

  modport source (output valid, status, entry_count, front_valid, front_tag, front_call,
                  front_dest, back_valid, back_tag, back_call, back_dest, input ready);
  modport sink   (input valid, status, entry_count, front_valid, front_tag, front_call,
                  front_dest, back_valid, back_tag, back_call, back_dest, output ready);
endinterface

@@ sv/srle_ctrl.sv @@
// Controller state machine of the sorted request list engine.
// Sequences scans, slot shifts and result capture; uses srle_pkg command and status types.
module srle_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  srle_pkg::srle_stat_t stat,
  output srle_pkg::srle_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SCAN_CHK,
    S_OPEN,
    S_OPEN_WR,
    S_CLOSE,
    S_CLOSE_WR,
    S_RES,
    S_FRONT_GET,
    S_BACK_GET
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.op_insert) begin
          if (stat.full) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = srle_pkg::STATUS_FULL;
            state_nxt       = S_RES;
          end else if (stat.op_front) begin
            cmd.pos_zero   = 1'b1;
            cmd.idx_to_occ = 1'b1;
            state_nxt      = S_OPEN;
          end else if (stat.op_back) begin
            cmd.pos_occ    = 1'b1;
            cmd.idx_to_occ = 1'b1;
            state_nxt      = S_OPEN;
          end else begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_SCAN;
          end
        end else if (stat.op_pop) begin
          if (stat.empty) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = srle_pkg::STATUS_EMPTY;
            state_nxt       = S_RES;
          end else begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_CLOSE;
          end
        end else if (stat.op_remove) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_SCAN;
        end else begin
          state_nxt = S_RES;
        end
      end
      S_SCAN: begin
        if (stat.idx_at_occ) begin
          if (stat.op_remove) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = srle_pkg::STATUS_NOT_FOUND;
            state_nxt       = S_RES;
          end else begin
            cmd.pos_idx    = 1'b1;
            cmd.idx_to_occ = 1'b1;
            state_nxt      = S_OPEN;
          end
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = srle_pkg::RD_IDX;
          state_nxt  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (stat.op_remove) begin
          if (stat.tag_hit) begin
            state_nxt = S_CLOSE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_SCAN;
          end
        end else if (stat.key_stop) begin
          cmd.pos_idx    = 1'b1;
          cmd.idx_to_occ = 1'b1;
          state_nxt      = S_OPEN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_OPEN: begin
        if (stat.idx_at_pos) begin
          cmd.wr_new  = 1'b1;
          cmd.occ_inc = 1'b1;
          state_nxt   = S_RES;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = srle_pkg::RD_IDX_PREV;
          state_nxt  = S_OPEN_WR;
        end
      end
      S_OPEN_WR: begin
        cmd.wr_move = 1'b1;
        cmd.idx_dec = 1'b1;
        state_nxt   = S_OPEN;
      end
      S_CLOSE: begin
        if (stat.close_end) begin
          cmd.occ_dec = 1'b1;
          state_nxt   = S_RES;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = srle_pkg::RD_IDX_NEXT;
          state_nxt  = S_CLOSE_WR;
        end
      end
      S_CLOSE_WR: begin
        cmd.wr_move = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_CLOSE;
      end
      S_RES: begin
        // The result registers are only rewritten once the previous result has left.
        if (!out_valid_r) begin
          if (stat.empty) begin
            cmd.clr_result = 1'b1;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = srle_pkg::RD_FRONT;
            state_nxt  = S_FRONT_GET;
          end
        end
      end
      S_FRONT_GET: begin
        cmd.cap_front = 1'b1;
        cmd.mem_rd    = 1'b1;
        cmd.rd_sel    = srle_pkg::RD_BACK;
        state_nxt     = S_BACK_GET;
      end
      S_BACK_GET: begin
        cmd.cap_back  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/srle_dp.sv @@
// Datapath of the sorted request list engine: entry memory, counters and result registers.
// Acts on srle_pkg commands from the controller and reports srle_pkg status back.
module srle_dp #(
  parameter int LIST_DEPTH = 16,
  parameter int FLOOR_BITS = 6,
  parameter int TAG_BITS   = 8,
  parameter int COUNT_BITS = 5,
  parameter int ADDR_BITS  = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [srle_pkg::FUNC_BITS-1:0]   in_func,
  input  logic [TAG_BITS-1:0]              in_user_tag,
  input  logic [FLOOR_BITS-1:0]            in_call_floor,
  input  logic [FLOOR_BITS-1:0]            in_dest_floor,
  input  srle_pkg::srle_cmd_t              cmd,
  output srle_pkg::srle_stat_t             stat,
  output logic [srle_pkg::STATUS_BITS-1:0] out_status,
  output logic [COUNT_BITS-1:0]            out_entry_count,
  output logic                             out_front_valid,
  output logic [TAG_BITS-1:0]              out_front_tag,
  output logic [FLOOR_BITS-1:0]            out_front_call,
  output logic [FLOOR_BITS-1:0]            out_front_dest,
  output logic                             out_back_valid,
  output logic [TAG_BITS-1:0]              out_back_tag,
  output logic [FLOOR_BITS-1:0]            out_back_call,
  output logic [FLOOR_BITS-1:0]            out_back_dest
);

  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [FLOOR_BITS-1:0] call;
    logic [FLOOR_BITS-1:0] dest;
  } entry_t;

  entry_t mem [LIST_DEPTH];

  logic [srle_pkg::FUNC_BITS-1:0]   func_r;
  entry_t                           new_r;
  entry_t                           rd_data_r;
  logic [COUNT_BITS-1:0]            occ_r;
  logic [COUNT_BITS-1:0]            idx_r;
  logic [COUNT_BITS-1:0]            pos_r;
  logic [srle_pkg::STATUS_BITS-1:0] work_status_r;

  logic [srle_pkg::STATUS_BITS-1:0] res_status_r;
  logic [COUNT_BITS-1:0]            res_count_r;
  logic                             res_valid_r;
  entry_t                           res_front_r;
  entry_t                           res_back_r;

  logic [COUNT_BITS-1:0] rd_idx;
  logic [COUNT_BITS:0]   idx_plus1;
  logic                  by_dest;
  logic                  ascending;
  logic [FLOOR_BITS-1:0] key_old;
  logic [FLOOR_BITS-1:0] key_new;

  // Operation decode.
  assign stat.op_insert = (func_r <= srle_pkg::FUNC_CALL_DESC);
  assign stat.op_front  = (func_r == srle_pkg::FUNC_PUSH_FRONT);
  assign stat.op_back   = (func_r == srle_pkg::FUNC_PUSH_BACK);
  assign stat.op_pop    = (func_r == srle_pkg::FUNC_POP);
  assign stat.op_remove = (func_r == srle_pkg::FUNC_REMOVE);

  assign stat.full       = (occ_r == COUNT_BITS'(LIST_DEPTH));
  assign stat.empty      = (occ_r == '0);
  assign stat.idx_at_occ = (idx_r == occ_r);
  assign stat.idx_at_pos = (idx_r == pos_r);
  assign idx_plus1       = {1'b0, idx_r} + 1'b1;
  assign stat.close_end  = (idx_plus1 >= {1'b0, occ_r});

  // Sorted insert stops at the first entry whose key is not strictly beyond the new key.
  assign by_dest   = (func_r == srle_pkg::FUNC_DEST_ASC) || (func_r == srle_pkg::FUNC_DEST_DESC);
  assign ascending = (func_r == srle_pkg::FUNC_DEST_ASC) || (func_r == srle_pkg::FUNC_CALL_ASC);
  assign key_old   = by_dest ? rd_data_r.dest : rd_data_r.call;
  assign key_new   = by_dest ? new_r.dest : new_r.call;
  assign stat.key_stop = ascending ? !(key_old < key_new) : !(key_old > key_new);
  assign stat.tag_hit  = (rd_data_r.tag == new_r.tag);

  always_comb begin
    case (cmd.rd_sel)
      srle_pkg::RD_IDX:      rd_idx = idx_r;
      srle_pkg::RD_IDX_PREV: rd_idx = idx_r - 1'b1;
      srle_pkg::RD_IDX_NEXT: rd_idx = idx_r + 1'b1;
      srle_pkg::RD_FRONT:    rd_idx = '0;
      srle_pkg::RD_BACK:     rd_idx = occ_r - 1'b1;
      default:               rd_idx = idx_r;
    endcase
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_move) begin
      mem[idx_r[ADDR_BITS-1:0]] <= rd_data_r;
    end else if (cmd.wr_new) begin
      mem[idx_r[ADDR_BITS-1:0]] <= new_r;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[rd_idx[ADDR_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.occ_inc) begin
      occ_r <= occ_r + 1'b1;
    end else if (cmd.occ_dec) begin
      occ_r <= occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r        <= in_func;
      new_r.tag     <= in_user_tag;
      new_r.call    <= in_call_floor;
      new_r.dest    <= in_dest_floor;
      work_status_r <= srle_pkg::STATUS_OK;
    end else if (cmd.set_status) begin
      work_status_r <= cmd.status_code;
    end

    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_to_occ) begin
      idx_r <= occ_r;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - 1'b1;
    end

    if (cmd.pos_zero) begin
      pos_r <= '0;
    end else if (cmd.pos_occ) begin
      pos_r <= occ_r;
    end else if (cmd.pos_idx) begin
      pos_r <= idx_r;
    end

    if (cmd.clr_result) begin
      res_status_r <= work_status_r;
      res_count_r  <= occ_r;
      res_valid_r  <= 1'b0;
      res_front_r  <= '0;
      res_back_r   <= '0;
    end
    if (cmd.cap_front) begin
      res_status_r <= work_status_r;
      res_count_r  <= occ_r;
      res_valid_r  <= 1'b1;
      res_front_r  <= rd_data_r;
    end
    if (cmd.cap_back) begin
      res_back_r <= rd_data_r;
    end
  end

  assign out_status      = res_status_r;
  assign out_entry_count = res_count_r;
  assign out_front_valid = res_valid_r;
  assign out_front_tag   = res_front_r.tag;
  assign out_front_call  = res_front_r.call;
  assign out_front_dest  = res_front_r.dest;
  assign out_back_valid  = res_valid_r;
  assign out_back_tag    = res_back_r.tag;
  assign out_back_call   = res_back_r.call;
  assign out_back_dest   = res_back_r.dest;

endmodule

@@ sv/sorted_request_list_engine.sv @@
// Top level of the sorted request list engine.
// Joins srle_ctrl and srle_dp; depends on srle_pkg, srle_in_if and srle_out_if.
//
// Usage: each item on in_chan carries an operation code (func) with a request tag,
// a call floor and a destination floor. The engine keeps an ordered list of up to
// LIST_DEPTH requests and answers every item with exactly one result item on
// out_chan: a status code, the entry count after the operation, and the front and
// back entries (zero with valid flags low when the list is empty).
// The time an item takes grows with each entry that a sorted or tag scan
// examines and with each entry that is shifted, on top of the dispatch and the
// result reads (fewer reads when the list ends up empty). Each examined entry
// is read from the entry memory and then checked, and each shifted entry is read
// and then written back one slot over. The next item can be accepted in the same
// cycle in which the result goes valid.
// One item is worked on at a time; in_chan.ready is high only while the engine is
// idle. A finished result sits in an output register, so the next item is taken
// while the receiver stalls; that item then waits before its result is written.
// Reset clears the entry count and the output valid flag; the list is empty.
module sorted_request_list_engine #(
  parameter int LIST_DEPTH = 16,
  parameter int FLOOR_BITS = 6,
  parameter int TAG_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  srle_in_if.sink     in_chan,
  srle_out_if.source  out_chan
);

  // The count must hold LIST_DEPTH itself; memory addresses only need depth-1.
  localparam int COUNT_BITS = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_BITS  = $clog2(LIST_DEPTH);

  srle_pkg::srle_cmd_t  cmd;
  srle_pkg::srle_stat_t stat;

  // The controller owns the handshakes and sequences every operation.
  srle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the list, its count and the result registers.
  srle_dp #(
    .LIST_DEPTH (LIST_DEPTH),
    .FLOOR_BITS (FLOOR_BITS),
    .TAG_BITS   (TAG_BITS),
    .COUNT_BITS (COUNT_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_func         (in_chan.func),
    .in_user_tag     (in_chan.user_tag),
    .in_call_floor   (in_chan.call_floor),
    .in_dest_floor   (in_chan.dest_floor),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_chan.status),
    .out_entry_count (out_chan.entry_count),
    .out_front_valid (out_chan.front_valid),
    .out_front_tag   (out_chan.front_tag),
    .out_front_call  (out_chan.front_call),
    .out_front_dest  (out_chan.front_dest),
    .out_back_valid  (out_chan.back_valid),
    .out_back_tag    (out_chan.back_tag),
    .out_back_call   (out_chan.back_call),
    .out_back_dest   (out_chan.back_dest)
  );

endmodule

@@ dv/tb_sorted_request_list_engine.sv @@
`timescale 1ns / 1ps
// Testbench for the sorted request list engine: directed and random request items
// with a predicting scoreboard. Depends on srle_pkg, srle_in_if, srle_out_if and
// sorted_request_list_engine.
module tb_sorted_request_list_engine;

  localparam int LIST_DEPTH = 16;
  localparam int FLOOR_BITS = 6;
  localparam int TAG_BITS   = 8;
  localparam int COUNT_BITS = 5;

  typedef logic [srle_pkg::FUNC_BITS-1:0] func_code_t;

  // Codes the engine does not define; it must treat them as a plain query.
  localparam func_code_t FUNC_UNUSED_LO = 4'd9;
  localparam func_code_t FUNC_UNUSED_HI = 4'd15;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int BLOCK_ITEMS    = 40;
  localparam int MAX_IDLE       = 13;
  localparam int TAIL_CYCLES    = 2 * LIST_DEPTH + 10;
  // Longest stretch without any accepted item: sender gap, engine work and a
  // receiver stall, taken many times over.
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum int {
    PHASE_FILL,
    PHASE_DRAIN,
    PHASE_MIXED
  } traffic_phase_t;

  // One result item as the engine reports it.
  typedef struct {
    logic [srle_pkg::STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]            entry_count;
    logic                             front_valid;
    logic [TAG_BITS-1:0]              front_tag;
    logic [FLOOR_BITS-1:0]            front_call;
    logic [FLOOR_BITS-1:0]            front_dest;
    logic                             back_valid;
    logic [TAG_BITS-1:0]              back_tag;
    logic [FLOOR_BITS-1:0]            back_call;
    logic [FLOOR_BITS-1:0]            back_dest;
  } list_report_t;

  // Keeps its own copy of the request list, works out the report that each
  // accepted request must produce, and checks the reports in order.
  class request_list_scoreboard;
    logic [TAG_BITS-1:0]   tag_at[LIST_DEPTH];
    logic [FLOOR_BITS-1:0] call_at[LIST_DEPTH];
    logic [FLOOR_BITS-1:0] dest_at[LIST_DEPTH];
    int unsigned           occupancy;
    list_report_t          expected_reports[$];
    int unsigned           error_count;

    function new();
      occupancy   = 0;
      error_count = 0;
    endfunction

    // True when the stored entry still sorts ahead of the new request.
    function bit sorts_ahead(func_code_t func, int unsigned idx,
                             logic [FLOOR_BITS-1:0] call, logic [FLOOR_BITS-1:0] dest);
      case (func)
        srle_pkg::FUNC_DEST_ASC:  return dest_at[idx] < dest;
        srle_pkg::FUNC_DEST_DESC: return dest_at[idx] > dest;
        srle_pkg::FUNC_CALL_ASC:  return call_at[idx] < call;
        default:                  return call_at[idx] > call;
      endcase
    endfunction

    function void drop_entry(int unsigned pos);
      int unsigned i;
      for (i = pos; i + 1 < occupancy; i++) begin
        tag_at[i]  = tag_at[i + 1];
        call_at[i] = call_at[i + 1];
        dest_at[i] = dest_at[i + 1];
      end
      occupancy--;
    endfunction

    function void note_request(func_code_t func, logic [TAG_BITS-1:0] tag,
                               logic [FLOOR_BITS-1:0] call, logic [FLOOR_BITS-1:0] dest);
      int unsigned  pos;
      int unsigned  i;
      list_report_t rpt;
      rpt.status = srle_pkg::STATUS_OK;
      if (func <= srle_pkg::FUNC_CALL_DESC) begin
        if (occupancy >= LIST_DEPTH) begin
          rpt.status = srle_pkg::STATUS_FULL;
        end else begin
          case (func)
            srle_pkg::FUNC_PUSH_FRONT: pos = 0;
            srle_pkg::FUNC_PUSH_BACK:  pos = occupancy;
            default: begin
              pos = 0;
              while (pos < occupancy && sorts_ahead(func, pos, call, dest)) pos++;
            end
          endcase
          for (i = occupancy; i > pos; i--) begin
            tag_at[i]  = tag_at[i - 1];
            call_at[i] = call_at[i - 1];
            dest_at[i] = dest_at[i - 1];
          end
          tag_at[pos]  = tag;
          call_at[pos] = call;
          dest_at[pos] = dest;
          occupancy++;
        end
      end else if (func == srle_pkg::FUNC_POP) begin
        if (occupancy == 0) rpt.status = srle_pkg::STATUS_EMPTY;
        else drop_entry(0);
      end else if (func == srle_pkg::FUNC_REMOVE) begin
        pos = 0;
        while (pos < occupancy && tag_at[pos] != tag) pos++;
        if (pos >= occupancy) rpt.status = srle_pkg::STATUS_NOT_FOUND;
        else drop_entry(pos);
      end
      rpt.entry_count = occupancy[COUNT_BITS-1:0];
      if (occupancy == 0) begin
        rpt.front_valid = 1'b0;
        rpt.front_tag   = '0;
        rpt.front_call  = '0;
        rpt.front_dest  = '0;
        rpt.back_valid  = 1'b0;
        rpt.back_tag    = '0;
        rpt.back_call   = '0;
        rpt.back_dest   = '0;
      end else begin
        rpt.front_valid = 1'b1;
        rpt.front_tag   = tag_at[0];
        rpt.front_call  = call_at[0];
        rpt.front_dest  = dest_at[0];
        rpt.back_valid  = 1'b1;
        rpt.back_tag    = tag_at[occupancy - 1];
        rpt.back_call   = call_at[occupancy - 1];
        rpt.back_dest   = dest_at[occupancy - 1];
      end
      expected_reports.push_back(rpt);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        error_count++;
      end
    endfunction

    function void check_result(list_report_t got);
      list_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t ns: result with no request pending, expected none, actual count %0d",
                 $time, got.entry_count);
        error_count++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("status",      want.status,      got.status);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("front_valid", want.front_valid, got.front_valid);
      compare_field("front_tag",   want.front_tag,   got.front_tag);
      compare_field("front_call",  want.front_call,  got.front_call);
      compare_field("front_dest",  want.front_dest,  got.front_dest);
      compare_field("back_valid",  want.back_valid,  got.back_valid);
      compare_field("back_tag",    want.back_tag,    got.back_tag);
      compare_field("back_call",   want.back_call,   got.back_call);
      compare_field("back_dest",   want.back_dest,   got.back_dest);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  srle_in_if  #(.TAG_BITS(TAG_BITS), .FLOOR_BITS(FLOOR_BITS)) req_chan ();
  srle_out_if #(.TAG_BITS(TAG_BITS), .FLOOR_BITS(FLOOR_BITS),
                .COUNT_BITS(COUNT_BITS)) rpt_chan ();

  sorted_request_list_engine #(
    .LIST_DEPTH(LIST_DEPTH),
    .FLOOR_BITS(FLOOR_BITS),
    .TAG_BITS  (TAG_BITS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (req_chan),
    .out_chan(rpt_chan)
  );

  request_list_scoreboard list_sb = new();

  // Idle behavior of each side; switched per block of items so that there are
  // stretches with back-to-back traffic as well as stretches full of gaps.
  bit          sender_idles;
  bit          receiver_idles;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // All inputs of the engine are known from time zero; they change only at
  // falling edges, so the engine sees them settled at every rising edge.
  initial begin
    rst_n               = 1'b0;
    req_chan.valid      = 1'b0;
    req_chan.func       = srle_pkg::FUNC_QUERY;
    req_chan.user_tag   = '0;
    req_chan.call_floor = '0;
    req_chan.dest_floor = '0;
    rpt_chan.ready      = 1'b0;
    sender_idles        = 1'b1;
    receiver_idles      = 1'b1;
  end

  // Both channels are sampled at the rising edge. A request is fed to the
  // scoreboard the moment it is accepted, so the sender already sees the new
  // list state when it picks the next request at the following falling edge.
  always @(posedge clk) begin : channel_monitor
    list_report_t seen;
    if (rst_n) begin
      if (req_chan.valid && req_chan.ready)
        list_sb.note_request(req_chan.func, req_chan.user_tag, req_chan.call_floor,
                             req_chan.dest_floor);
      if (rpt_chan.valid && rpt_chan.ready) begin
        seen.status      = rpt_chan.status;
        seen.entry_count = rpt_chan.entry_count;
        seen.front_valid = rpt_chan.front_valid;
        seen.front_tag   = rpt_chan.front_tag;
        seen.front_call  = rpt_chan.front_call;
        seen.front_dest  = rpt_chan.front_dest;
        seen.back_valid  = rpt_chan.back_valid;
        seen.back_tag    = rpt_chan.back_tag;
        seen.back_call   = rpt_chan.back_call;
        seen.back_dest   = rpt_chan.back_dest;
        list_sb.check_result(seen);
      end
    end
  end

  // The watchdog ends a run that stops moving: no item accepted on either
  // channel for far longer than the slowest legal item could take.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((req_chan.valid && req_chan.ready) || (rpt_chan.valid && rpt_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_sorted_request_list_engine: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // When receiver_idles is set, the receiver stalls for a random number of cycles
  // before each result; it then keeps ready high until a result is taken.
  initial begin : report_receiver
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall != 0) begin
        rpt_chan.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rpt_chan.ready = 1'b1;
      do @(posedge clk); while (!rpt_chan.valid);
      @(negedge clk);
    end
  end

  // Offers one request and returns at the falling edge after it was taken.
  // Valid stays high when the next request follows without a gap.
  task automatic send_request(func_code_t func, logic [TAG_BITS-1:0] tag,
                              logic [FLOOR_BITS-1:0] call, logic [FLOOR_BITS-1:0] dest);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      req_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_chan.func       = func;
    req_chan.user_tag   = tag;
    req_chan.call_floor = call;
    req_chan.dest_floor = dest;
    req_chan.valid      = 1'b1;
    do @(posedge clk); while (!req_chan.ready);
    @(negedge clk);
  endtask

  // Holds the sender off until every outstanding report has come back.
  task automatic wait_for_reports();
    req_chan.valid = 1'b0;
    while (list_sb.expected_reports.size() != 0) @(negedge clk);
  endtask

  // Floors are often taken from the ends of the range so that equal keys,
  // which must go in front of their equals, turn up regularly.
  function automatic logic [FLOOR_BITS-1:0] pick_floor();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return FLOOR_BITS'($urandom_range(0, 3));
    if (roll < 30) return FLOOR_BITS'($urandom_range(60, 63));
    return FLOOR_BITS'($urandom_range(0, 63));
  endfunction

  // One random request, weighted by the traffic phase. Fill phases push the
  // list up to full and keep trying inserts there; drain phases empty it and
  // then keep popping; removals mostly name a tag that is in the list.
  task automatic send_random_request(traffic_phase_t phase);
    int unsigned           roll;
    int unsigned           insert_pct;
    int unsigned           pop_pct;
    func_code_t            func;
    logic [TAG_BITS-1:0]   tag;
    roll = $urandom_range(0, 99);
    case (phase)
      PHASE_FILL: begin
        insert_pct = 85;
        pop_pct    = 5;
      end
      PHASE_DRAIN: begin
        insert_pct = 15;
        pop_pct    = 40;
      end
      default: begin
        insert_pct = 50;
        pop_pct    = 20;
      end
    endcase
    if (roll < insert_pct)
      func = func_code_t'($urandom_range(srle_pkg::FUNC_PUSH_FRONT, srle_pkg::FUNC_CALL_DESC));
    else if (roll < insert_pct + pop_pct)
      func = srle_pkg::FUNC_POP;
    else if (roll < 92)
      func = srle_pkg::FUNC_REMOVE;
    else
      func = func_code_t'($urandom_range(srle_pkg::FUNC_QUERY, FUNC_UNUSED_HI));

    // A narrow tag range makes duplicate tags, so removal must take the first.
    if ($urandom_range(0, 99) < 30) tag = TAG_BITS'($urandom_range(0, 7));
    else tag = TAG_BITS'($urandom_range(0, 255));
    if (func == srle_pkg::FUNC_REMOVE && list_sb.occupancy != 0 && $urandom_range(0, 99) < 70)
      tag = list_sb.tag_at[$urandom_range(0, list_sb.occupancy - 1)];
    send_request(func, tag, pick_floor(), pick_floor());
  endtask

  initial begin : stimulus
    int             block;
    int             n;
    traffic_phase_t phase;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: the empty list for query, pop, removal and a front push, the
    // field extremes, each insert kind including a tie on the key, removal of a
    // present and of a missing tag, and the undefined codes.
    send_request(srle_pkg::FUNC_QUERY,      8'd0,   6'd0,  6'd0);
    send_request(srle_pkg::FUNC_POP,        8'd0,   6'd0,  6'd0);
    send_request(srle_pkg::FUNC_REMOVE,     8'd255, 6'd63, 6'd63);
    send_request(srle_pkg::FUNC_PUSH_FRONT, 8'd255, 6'd63, 6'd63);
    send_request(srle_pkg::FUNC_PUSH_BACK,  8'd0,   6'd0,  6'd0);
    send_request(srle_pkg::FUNC_DEST_ASC,   8'd1,   6'd10, 6'd30);
    send_request(srle_pkg::FUNC_DEST_DESC,  8'd2,   6'd20, 6'd30);
    send_request(srle_pkg::FUNC_CALL_ASC,   8'd3,   6'd20, 6'd5);
    send_request(srle_pkg::FUNC_CALL_DESC,  8'd4,   6'd63, 6'd0);
    send_request(srle_pkg::FUNC_CALL_ASC,   8'd5,   6'd20, 6'd40);
    send_request(srle_pkg::FUNC_REMOVE,     8'd3,   6'd0,  6'd0);
    send_request(srle_pkg::FUNC_REMOVE,     8'd200, 6'd0,  6'd0);
    send_request(FUNC_UNUSED_HI,            8'd170, 6'd42, 6'd21);
    send_request(FUNC_UNUSED_LO,            8'd85,  6'd21, 6'd42);
    send_request(srle_pkg::FUNC_POP,        8'd0,   6'd0,  6'd0);
    send_request(srle_pkg::FUNC_PUSH_BACK,  8'd170, 6'd42, 6'd21);
    send_request(srle_pkg::FUNC_REMOVE,     8'd0,   6'd0,  6'd0);
    wait_for_reports();

    // Random part in blocks, each with its own traffic phase and idle habits.
    // Every fifth block the sender waits for all reports before going on.
    for (block = 0; block < RANDOM_ITEMS / BLOCK_ITEMS; block++) begin
      phase          = traffic_phase_t'($urandom_range(PHASE_FILL, PHASE_MIXED));
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      if (block % 5 == 4) wait_for_reports();
      for (n = 0; n < BLOCK_ITEMS; n++) send_random_request(phase);
    end
    req_chan.valid = 1'b0;

    while (list_sb.expected_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (list_sb.expected_reports.size() != 0) begin
      $display("%0t ns: reports missing at the end, expected 0 pending, actual %0d",
               $time, list_sb.expected_reports.size());
      list_sb.error_count++;
    end
    if (list_sb.error_count == 0) begin
      $display("tb_sorted_request_list_engine: PASS");
    end else begin
      $display("tb_sorted_request_list_engine: FAIL");
    end
    $finish;
  end

endmodule
